### src/fpba_pkg.sv
package fpba_pkg;

	localparam int ACTION_W = 2;
	localparam int SELECT_W = 5;
	localparam int SIZE_W   = 16;
	localparam int MODE_W   = 2;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [ACTION_W-1:0] ACT_LOAD     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ALLOCATE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESTORE  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SELECT_W-1:0] block_select;
		logic [SIZE_W-1:0]   size_value;
	} cmd_t;

	typedef struct packed {
		logic                allocated;
		logic [SELECT_W-1:0] chosen_block;
		logic [SIZE_W-1:0]   left_over;
	} rsp_t;

endpackage

### src/fpba_ram.sv
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/fit_policy_block_allocator.sv
// Channel  | Signals                              | Accepted when
// ---------+--------------------------------------+------------------------------
// command  | start, busy, cmd                     | start && !busy at clk edge
// result   | rsp_valid, rsp                       | every cycle rsp_valid is high
// config   | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// Load: S_LOAD writes the entry, then S_DONE gives the result strobe; an unused action goes to S_DONE.
// Allocate: S_SCAN searches the blocks in use, then S_UPDATE (only when a block is chosen) writes back
// its remaining size, then S_DONE; the remaining-size RAM is read one entry a cycle by the single compare unit.
// Restore: every entry is copied from the original-size RAM, one entry a cycle. busy is high for the whole item.
// Reset clears control and configuration; table contents are unset until loaded.
// The result strobe lasts one cycle and cannot be held off.
module fit_policy_block_allocator #(
	parameter int MAX_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fpba_pkg::cmd_t                    cmd,
	output logic                              rsp_valid,
	output fpba_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_LOAD    = 3'd1;
	localparam logic [2:0] S_RESTORE = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_UPDATE  = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]                      state_q;
	logic [fpba_pkg::MODE_W-1:0]     fit_mode_q;
	logic [fpba_pkg::COUNT_W-1:0]    blocks_in_use_q;
	logic [fpba_pkg::SELECT_W-1:0]   sel_q;
	logic [SIZE_BITS-1:0]            size_q;
	logic [CW-1:0]                   limit_q;
	logic [CW-1:0]                   ctr_q;
	logic                            pend_q;
	logic [AW-1:0]                   tag_q;
	logic                            found_q;
	logic [AW-1:0]                   pick_q;
	logic [SIZE_BITS-1:0]            best_q;
	fpba_pkg::rsp_t                  rsp_q;

	logic                            accept;
	logic                            orig_we;
	logic [AW-1:0]                   orig_waddr;
	logic [SIZE_BITS-1:0]            orig_rdata;
	logic                            rem_we;
	logic [AW-1:0]                   rem_waddr;
	logic [SIZE_BITS-1:0]            rem_wdata;
	logic [SIZE_BITS-1:0]            rem_rdata;
	logic [AW-1:0]                   raddr;
	logic [SIZE_BITS-1:0]            new_left;
	logic                            fits;
	logic                            take;
	logic                            sel_ok;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign raddr    = ctr_q[AW-1:0];
	assign new_left = best_q - size_q;
	assign sel_ok   = (32'(sel_q) < MAX_BLOCKS);
	assign fits     = (rem_rdata >= size_q);

	always_comb begin
		take = 1'b0;
		if (pend_q && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_mode_q == fpba_pkg::MODE_BEST) begin
				take = (rem_rdata < best_q);
			end else if (fit_mode_q == fpba_pkg::MODE_WORST) begin
				take = (rem_rdata > best_q);
			end
		end
	end

	always_comb begin
		orig_we    = 1'b0;
		orig_waddr = AW'(sel_q);
		rem_we     = 1'b0;
		rem_waddr  = AW'(sel_q);
		rem_wdata  = size_q;
		case (state_q)
			S_LOAD: begin
				orig_we = sel_ok;
				rem_we  = sel_ok;
			end
			S_RESTORE: begin
				rem_we    = pend_q;
				rem_waddr = tag_q;
				rem_wdata = orig_rdata;
			end
			S_UPDATE: begin
				rem_we    = 1'b1;
				rem_waddr = pick_q;
				rem_wdata = new_left;
			end
			default: begin
			end
		endcase
	end

	fpba_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_orig_ram (
		.clk   (clk),
		.we    (orig_we),
		.waddr (orig_waddr),
		.wdata (size_q),
		.raddr (raddr),
		.rdata (orig_rdata)
	);

	fpba_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (raddr),
		.rdata (rem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q      <= fpba_pkg::MODE_FIRST;
			blocks_in_use_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpba_pkg::REG_FIT_MODE:      fit_mode_q <= cfg_data[fpba_pkg::MODE_W-1:0];
				fpba_pkg::REG_BLOCKS_IN_USE: blocks_in_use_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctr_q   <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ctr_q   <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						case (cmd.action)
							fpba_pkg::ACT_LOAD:     state_q <= S_LOAD;
							fpba_pkg::ACT_ALLOCATE: state_q <= S_SCAN;
							fpba_pkg::ACT_RESTORE:  state_q <= S_RESTORE;
							default:                state_q <= S_DONE;
						endcase
					end
				end
				S_LOAD: begin
					state_q <= S_DONE;
				end
				S_RESTORE: begin
					if (32'(ctr_q) < MAX_BLOCKS) begin
						ctr_q  <= ctr_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (ctr_q < limit_q) begin
						ctr_q  <= ctr_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= found_q ? S_UPDATE : S_DONE;
						end
					end
				end
				S_UPDATE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= raddr;
		if (accept) begin
			sel_q  <= cmd.block_select;
			size_q <= SIZE_BITS'(cmd.size_value);
			rsp_q  <= '0;
			if (32'(blocks_in_use_q) > MAX_BLOCKS) begin
				limit_q <= CW'(MAX_BLOCKS);
			end else begin
				limit_q <= CW'(blocks_in_use_q);
			end
		end
		if (state_q == S_SCAN && take) begin
			pick_q <= tag_q;
			best_q <= rem_rdata;
		end
		if (state_q == S_UPDATE) begin
			rsp_q.allocated    <= 1'b1;
			rsp_q.chosen_block <= fpba_pkg::SELECT_W'(pick_q);
			rsp_q.left_over    <= fpba_pkg::SIZE_W'(new_left);
		end
	end

endmodule
